// ----- rtl/bbc_pkg.sv -----
// Shared constants, types and helpers for the bracket balance checker.
// No dependencies; every other file refers to this package by scoped names.
package bbc_pkg;

	localparam int STACK_DEPTH = 1024;
	localparam int LINE_BITS   = 24;
	localparam int COUNT_BITS  = 16;

	localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	localparam int MAX_RESULTS = 3;
	localparam int FIFO_DEPTH  = 4;
	localparam int PTR_W       = $clog2(FIFO_DEPTH);
	localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

	localparam logic [LINE_BITS-1:0]  LINE_MAX  = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;

	localparam logic [1:0] OPEN_PAREN   = 2'd0;
	localparam logic [1:0] OPEN_BRACKET = 2'd1;
	localparam logic [1:0] OPEN_BRACE   = 2'd2;

	localparam logic [2:0] ERR_UNMATCHED    = 3'd0;
	localparam logic [2:0] ERR_MISMATCH     = 3'd1;
	localparam logic [2:0] ERR_OVERFLOW     = 3'd2;
	localparam logic [2:0] ERR_OPEN_COMMENT = 3'd3;
	localparam logic [2:0] ERR_END_ESCAPE   = 3'd4;
	localparam logic [2:0] ERR_OPEN_QUOTE   = 3'd5;
	localparam logic [2:0] ERR_LEFTOVER     = 3'd6;
	localparam logic [2:0] ERR_NONE         = 3'd0;

	localparam logic REC_ERROR   = 1'b0;
	localparam logic REC_SUMMARY = 1'b1;

	typedef struct packed {
		logic                  record_kind;
		logic [2:0]            error_code;
		logic [LINE_BITS-1:0]  line_number;
		logic [7:0]            opening_seen;
		logic [7:0]            closing_seen;
		logic [COUNT_BITS-1:0] error_total;
		logic                  check_passed;
		logic                  last_of_run;
	} result_t;

	typedef struct packed {
		logic [RCNT_W-1:0]             cnt;
		result_t [MAX_RESULTS-1:0]     rec;
	} res_bundle_t;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic       clear;
		logic [1:0] code;
	} stack_op_t;

	function automatic logic [7:0] opener_char(input logic [1:0] code);
		logic [7:0] ch;
		case (code)
			OPEN_PAREN:   ch = CH_LPAREN;
			OPEN_BRACKET: ch = CH_LBRACKET;
			OPEN_BRACE:   ch = CH_LBRACE;
			default:      ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [COUNT_BITS-1:0] sat_inc_err(input logic [COUNT_BITS-1:0] v);
		return (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
	endfunction

	function automatic result_t make_rec(
		input logic                  kind,
		input logic [2:0]            code,
		input logic [LINE_BITS-1:0]  line,
		input logic [7:0]            op_ch,
		input logic [7:0]            cl_ch,
		input logic [COUNT_BITS-1:0] total,
		input logic                  passed
	);
		result_t r;
		r.record_kind  = kind;
		r.error_code   = code;
		r.line_number  = line;
		r.opening_seen = op_ch;
		r.closing_seen = cl_ch;
		r.error_total  = total;
		r.check_passed = passed;
		r.last_of_run  = 1'b0;
		return r;
	endfunction

endpackage

// ----- rtl/bbc_ifs.sv -----
// Valid/ready channel interfaces for text input and result output.
// Depends on bbc_pkg for field widths.
interface bbc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface bbc_out_if;
	logic                           valid;
	logic                           ready;
	logic                           record_kind;
	logic [2:0]                     error_code;
	logic [bbc_pkg::LINE_BITS-1:0]  line_number;
	logic [7:0]                     opening_seen;
	logic [7:0]                     closing_seen;
	logic [bbc_pkg::COUNT_BITS-1:0] error_total;
	logic                           check_passed;
	logic                           last_of_run;

	modport source (output valid, output record_kind, output error_code, output line_number,
		output opening_seen, output closing_seen, output error_total, output check_passed,
		output last_of_run, input ready);
	modport sink (input valid, input record_kind, input error_code, input line_number,
		input opening_seen, input closing_seen, input error_total, input check_passed,
		input last_of_run, output ready);
endinterface

// ----- rtl/bbc_stack.sv -----
// Bracket stack: synchronous 2-bit memory plus cached top entry and depth.
// The entry below the top is prefetched every cycle. Depends on bbc_pkg.
module bbc_stack (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bbc_pkg::stack_op_t            op,
	output logic [bbc_pkg::DEPTH_W-1:0]   depth,
	output logic [1:0]                    top
);

	logic [1:0]                  mem [bbc_pkg::STACK_DEPTH];
	logic [1:0]                  below_q;
	logic [bbc_pkg::DEPTH_W-1:0] depth_q;
	logic [bbc_pkg::DEPTH_W-1:0] depth_d;
	logic [1:0]                  top_q;
	logic [bbc_pkg::DEPTH_W-1:0] rd_full;
	logic [bbc_pkg::ADDR_W-1:0]  rd_addr;
	logic [bbc_pkg::ADDR_W-1:0]  wr_addr;

	always_comb begin
		depth_d = depth_q;
		if (op.clear) begin
			depth_d = '0;
		end else if (op.push) begin
			depth_d = depth_q + bbc_pkg::DEPTH_W'(1);
		end else if (op.pop) begin
			depth_d = depth_q - bbc_pkg::DEPTH_W'(1);
		end
	end

	// prefetch entry below the new top; never the address written this cycle
	assign rd_full = depth_d - bbc_pkg::DEPTH_W'(2);
	assign rd_addr = rd_full[bbc_pkg::ADDR_W-1:0];
	assign wr_addr = depth_q[bbc_pkg::ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (op.push) begin
			mem[wr_addr] <= op.code;
		end
		below_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			top_q   <= '0;
		end else begin
			depth_q <= depth_d;
			if (op.push) begin
				top_q <= op.code;
			end else if (op.pop) begin
				top_q <= below_q;
			end
		end
	end

	assign depth = depth_q;
	assign top   = top_q;

	a_push_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(op.push && op.pop)) else $error("push and pop together");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		op.push |-> depth_q < bbc_pkg::DEPTH_W'(bbc_pkg::STACK_DEPTH))
		else $error("push on full stack");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		op.pop |-> depth_q != '0) else $error("pop on empty stack");
	a_pop_depth: assert property (@(posedge clk) disable iff (!arst_n)
		op.pop && !op.clear |=> depth_q == $past(depth_q) - bbc_pkg::DEPTH_W'(1))
		else $error("depth not decremented");

endmodule

// ----- rtl/bbc_scanner.sv -----
// Scan state machine: comment/quote modes, line and error counters,
// stack control and result generation. Depends on bbc_pkg and bbc_ifs.
module bbc_scanner (
	input  logic                         clk,
	input  logic                         arst_n,
	bbc_in_if.sink                       in_ch,
	input  logic                         space_ok,
	input  logic [bbc_pkg::DEPTH_W-1:0]  depth,
	input  logic [1:0]                   top,
	output bbc_pkg::stack_op_t           op,
	output bbc_pkg::res_bundle_t         bun
);

	typedef enum logic [2:0] {
		M_CODE,
		M_SLASH,
		M_BLOCK,
		M_BLOCK_STAR,
		M_LINE,
		M_QUOTE,
		M_ESCAPE
	} mode_t;

	mode_t                          mode_q;
	mode_t                          mode_d;
	logic                           dbl_q;
	logic                           dbl_d;
	logic [bbc_pkg::LINE_BITS-1:0]  line_q;
	logic [bbc_pkg::LINE_BITS-1:0]  line_d;
	logic [bbc_pkg::COUNT_BITS-1:0] err_q;
	logic [bbc_pkg::COUNT_BITS-1:0] err_d;
	logic                           accept;

	assign in_ch.ready = space_ok;
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		logic [7:0]                     c;
		logic [7:0]                     qc;
		logic                           do_code;
		logic                           rep;
		logic [2:0]                     rcode;
		logic [7:0]                     ro;
		logic [7:0]                     rc;
		logic [1:0]                     want;
		logic                           is_close;
		logic [bbc_pkg::RCNT_W-1:0]     n;
		logic [bbc_pkg::COUNT_BITS-1:0] e;

		c        = in_ch.text_byte;
		qc       = dbl_q ? bbc_pkg::CH_DQUOTE : bbc_pkg::CH_SQUOTE;
		do_code  = 1'b0;
		rep      = 1'b0;
		rcode    = bbc_pkg::ERR_NONE;
		ro       = 8'h00;
		rc       = 8'h00;
		want     = bbc_pkg::OPEN_PAREN;
		is_close = 1'b0;
		n        = '0;
		e        = err_q;
		mode_d   = mode_q;
		dbl_d    = dbl_q;
		line_d   = line_q;
		err_d    = err_q;
		op       = '0;
		bun      = '0;

		if (accept && in_ch.end_of_text) begin
			if (mode_q == M_BLOCK || mode_q == M_BLOCK_STAR) begin
				e = bbc_pkg::sat_inc_err(e);
				bun.rec[n] = bbc_pkg::make_rec(bbc_pkg::REC_ERROR, bbc_pkg::ERR_OPEN_COMMENT,
					line_q, 8'h00, 8'h00, e, 1'b0);
				n = n + bbc_pkg::RCNT_W'(1);
			end else if (mode_q == M_ESCAPE) begin
				e = bbc_pkg::sat_inc_err(e);
				bun.rec[n] = bbc_pkg::make_rec(bbc_pkg::REC_ERROR, bbc_pkg::ERR_END_ESCAPE,
					line_q, qc, 8'h00, e, 1'b0);
				n = n + bbc_pkg::RCNT_W'(1);
			end else if (mode_q == M_QUOTE) begin
				e = bbc_pkg::sat_inc_err(e);
				bun.rec[n] = bbc_pkg::make_rec(bbc_pkg::REC_ERROR, bbc_pkg::ERR_OPEN_QUOTE,
					line_q, qc, 8'h00, e, 1'b0);
				n = n + bbc_pkg::RCNT_W'(1);
			end
			if (depth != '0) begin
				e = bbc_pkg::sat_inc_err(e);
				bun.rec[n] = bbc_pkg::make_rec(bbc_pkg::REC_ERROR, bbc_pkg::ERR_LEFTOVER,
					line_q, bbc_pkg::opener_char(top), 8'h00, e, 1'b0);
				n = n + bbc_pkg::RCNT_W'(1);
			end
			bun.rec[n] = bbc_pkg::make_rec(bbc_pkg::REC_SUMMARY, bbc_pkg::ERR_NONE,
				line_q, 8'h00, 8'h00, e, e == '0);
			bun.rec[n].last_of_run = 1'b1;
			bun.cnt  = n + bbc_pkg::RCNT_W'(1);
			op.clear = 1'b1;
			mode_d   = M_CODE;
			dbl_d    = 1'b0;
			line_d   = bbc_pkg::LINE_BITS'(1);
			err_d    = '0;
		end else if (accept) begin
			if (c == bbc_pkg::CH_NEWLINE && line_q != bbc_pkg::LINE_MAX) begin
				line_d = line_q + bbc_pkg::LINE_BITS'(1);
			end
			case (mode_q)
				M_SLASH: begin
					if (c == bbc_pkg::CH_STAR) begin
						mode_d = M_BLOCK;
					end else if (c == bbc_pkg::CH_SLASH) begin
						mode_d = M_LINE;
					end else begin
						do_code = 1'b1;
					end
				end
				M_BLOCK: begin
					if (c == bbc_pkg::CH_STAR) begin
						mode_d = M_BLOCK_STAR;
					end
				end
				M_BLOCK_STAR: begin
					if (c == bbc_pkg::CH_SLASH) begin
						mode_d = M_CODE;
					end else if (c != bbc_pkg::CH_STAR) begin
						mode_d = M_BLOCK;
					end
				end
				M_LINE: begin
					if (c == bbc_pkg::CH_NEWLINE) begin
						mode_d = M_CODE;
					end
				end
				M_QUOTE: begin
					if (c == qc) begin
						mode_d = M_CODE;
					end else if (c == bbc_pkg::CH_BACKSLASH) begin
						mode_d = M_ESCAPE;
					end
				end
				M_ESCAPE: begin
					mode_d = M_QUOTE;
				end
				default: begin
					do_code = 1'b1;
				end
			endcase

			if (do_code) begin
				mode_d = M_CODE;
				case (c)
					bbc_pkg::CH_SLASH: mode_d = M_SLASH;
					bbc_pkg::CH_SQUOTE: begin
						mode_d = M_QUOTE;
						dbl_d  = 1'b0;
					end
					bbc_pkg::CH_DQUOTE: begin
						mode_d = M_QUOTE;
						dbl_d  = 1'b1;
					end
					bbc_pkg::CH_LPAREN, bbc_pkg::CH_LBRACKET, bbc_pkg::CH_LBRACE: begin
						if (depth < bbc_pkg::DEPTH_W'(bbc_pkg::STACK_DEPTH)) begin
							op.push = 1'b1;
							op.code = (c == bbc_pkg::CH_LPAREN) ? bbc_pkg::OPEN_PAREN :
								(c == bbc_pkg::CH_LBRACKET) ? bbc_pkg::OPEN_BRACKET :
								bbc_pkg::OPEN_BRACE;
						end else begin
							rep   = 1'b1;
							rcode = bbc_pkg::ERR_OVERFLOW;
							ro    = c;
						end
					end
					bbc_pkg::CH_RPAREN: begin
						is_close = 1'b1;
						want     = bbc_pkg::OPEN_PAREN;
					end
					bbc_pkg::CH_RBRACKET: begin
						is_close = 1'b1;
						want     = bbc_pkg::OPEN_BRACKET;
					end
					bbc_pkg::CH_RBRACE: begin
						is_close = 1'b1;
						want     = bbc_pkg::OPEN_BRACE;
					end
					default: begin
					end
				endcase
			end

			if (is_close) begin
				rc = c;
				if (depth == '0) begin
					rep   = 1'b1;
					rcode = bbc_pkg::ERR_UNMATCHED;
				end else begin
					op.pop = 1'b1;
					if (top != want) begin
						rep   = 1'b1;
						rcode = bbc_pkg::ERR_MISMATCH;
						ro    = bbc_pkg::opener_char(top);
					end
				end
			end

			if (rep) begin
				err_d = bbc_pkg::sat_inc_err(err_q);
				bun.rec[0] = bbc_pkg::make_rec(bbc_pkg::REC_ERROR, rcode, line_d, ro, rc,
					err_d, 1'b0);
				bun.rec[0].last_of_run = 1'b1;
				bun.cnt = bbc_pkg::RCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_CODE;
			dbl_q  <= 1'b0;
			line_q <= bbc_pkg::LINE_BITS'(1);
			err_q  <= '0;
		end else begin
			mode_q <= mode_d;
			dbl_q  <= dbl_d;
			line_q <= line_d;
			err_q  <= err_d;
		end
	end

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0) else $error("line counter reached zero");
	a_results_need_space: assert property (@(posedge clk) disable iff (!arst_n)
		bun.cnt != '0 |-> space_ok) else $error("results without queue space");
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_ch.end_of_text |=> mode_q == M_CODE && err_q == '0)
		else $error("state not reset after end of text");

endmodule

// ----- rtl/bbc_out_fifo.sv -----
// Result queue: takes up to three results per cycle, gives one per transfer.
// Depends on bbc_pkg and bbc_ifs.
module bbc_out_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bbc_pkg::res_bundle_t  bun,
	output logic                  space_ok,
	bbc_out_if.source             out_ch
);

	bbc_pkg::result_t            fifo_q [bbc_pkg::FIFO_DEPTH];
	bbc_pkg::result_t            head;
	logic [bbc_pkg::PTR_W-1:0]   wr_q;
	logic [bbc_pkg::PTR_W-1:0]   rd_q;
	logic [bbc_pkg::FCNT_W-1:0]  cnt_q;
	logic                        pop;

	assign space_ok = cnt_q <= bbc_pkg::FCNT_W'(bbc_pkg::FIFO_DEPTH - bbc_pkg::MAX_RESULTS);
	assign pop      = out_ch.valid && out_ch.ready;
	assign head     = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < bbc_pkg::MAX_RESULTS; i++) begin
			if (bbc_pkg::RCNT_W'(i) < bun.cnt) begin
				fifo_q[wr_q + bbc_pkg::PTR_W'(i)] <= bun.rec[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + bbc_pkg::PTR_W'(bun.cnt);
			rd_q  <= rd_q + bbc_pkg::PTR_W'(pop);
			cnt_q <= cnt_q + bbc_pkg::FCNT_W'(bun.cnt) - bbc_pkg::FCNT_W'(pop);
		end
	end

	assign out_ch.valid        = cnt_q != '0;
	assign out_ch.record_kind  = head.record_kind;
	assign out_ch.error_code   = head.error_code;
	assign out_ch.line_number  = head.line_number;
	assign out_ch.opening_seen = head.opening_seen;
	assign out_ch.closing_seen = head.closing_seen;
	assign out_ch.error_total  = head.error_total;
	assign out_ch.check_passed = head.check_passed;
	assign out_ch.last_of_run  = head.last_of_run;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= bbc_pkg::FCNT_W'(bbc_pkg::FIFO_DEPTH)) else $error("queue overflow");
	a_err_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.record_kind == bbc_pkg::REC_ERROR |-> out_ch.error_total != '0)
		else $error("error report with zero total");
	a_pass_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.record_kind == bbc_pkg::REC_SUMMARY |->
		out_ch.last_of_run && (out_ch.check_passed == (out_ch.error_total == '0)))
		else $error("bad summary record");

endmodule

// ----- rtl/bracket_balance_checker.sv -----
// Bracket, quote and comment checker for C source text, one byte per transfer.
// An item is taken every cycle while the result queue has room for three results;
// a text byte gives at most one error report, the end-of-text item up to two reports
// and the summary. The bracket stack is a 1024 x 2 synchronous memory with a cached
// top entry and a prefetched entry below it, so pushes and pops run back to back;
// it needs no clearing pass after reset. Results leave through a 4-entry queue, so
// the input keeps flowing while a result waits for the sink.
// Depends on bbc_pkg, bbc_ifs, bbc_stack, bbc_scanner and bbc_out_fifo.
module bracket_balance_checker (
	input  logic       clk,
	input  logic       arst_n,
	bbc_in_if.sink     in_ch,
	bbc_out_if.source  out_ch
);

	bbc_pkg::stack_op_t          op;
	bbc_pkg::res_bundle_t        bun;
	logic [bbc_pkg::DEPTH_W-1:0] depth;
	logic [1:0]                  top;
	logic                        space_ok;

	bbc_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.depth  (depth),
		.top    (top)
	);

	bbc_scanner u_scanner (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.space_ok (space_ok),
		.depth    (depth),
		.top      (top),
		.op       (op),
		.bun      (bun)
	);

	bbc_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.bun      (bun),
		.space_ok (space_ok),
		.out_ch   (out_ch)
	);

endmodule
